FILE: design/rvamo_pkg.sv
package rvamo_pkg;

   localparam int XLEN = 64;

   // Operation codes (funct5).
   localparam logic [4:0] KIND_ADD  = 5'b00000;
   localparam logic [4:0] KIND_SWAP = 5'b00001;
   localparam logic [4:0] KIND_LR   = 5'b00010;
   localparam logic [4:0] KIND_SC   = 5'b00011;
   localparam logic [4:0] KIND_XOR  = 5'b00100;
   localparam logic [4:0] KIND_CAS  = 5'b00101;
   localparam logic [4:0] KIND_OR   = 5'b01000;
   localparam logic [4:0] KIND_AND  = 5'b01100;
   localparam logic [4:0] KIND_MIN  = 5'b10000;
   localparam logic [4:0] KIND_MAX  = 5'b10100;
   localparam logic [4:0] KIND_MINU = 5'b11000;
   localparam logic [4:0] KIND_MAXU = 5'b11100;

   // Size codes (funct3).
   localparam logic [2:0] SIZE_BYTE   = 3'd0;
   localparam logic [2:0] SIZE_HALF   = 3'd1;
   localparam logic [2:0] SIZE_WORD   = 3'd2;
   localparam logic [2:0] SIZE_DOUBLE = 3'd3;
   localparam logic [2:0] SIZE_QUAD   = 3'b100;

   // Result status codes.
   localparam logic [2:0] STATUS_OK             = 3'd0;
   localparam logic [2:0] STATUS_ILLEGAL        = 3'd1;
   localparam logic [2:0] STATUS_LOAD_FAULT     = 3'd2;
   localparam logic [2:0] STATUS_STORE_FAULT    = 3'd3;
   localparam logic [2:0] STATUS_LOAD_MISALIGN  = 3'd4;
   localparam logic [2:0] STATUS_STORE_MISALIGN = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_GRANULE_BITS = 2'd0;
   localparam logic [1:0] CSR_BYTE_HALF    = 2'd1;
   localparam logic [1:0] CSR_CAS          = 2'd2;

   localparam logic [3:0] GRANULE_BITS_RESET = 4'd6;

   typedef struct packed {
      logic [4:0]      kind;
      logic [2:0]      size_code;
      logic [4:0]      dest_reg;
      logic [4:0]      src2_reg;
      logic [XLEN-1:0] phys_addr;
      logic            access_fault;
      logic [XLEN-1:0] mem_lo;
      logic [XLEN-1:0] mem_hi;
      logic [XLEN-1:0] src2_lo;
      logic [XLEN-1:0] src2_hi;
      logic [XLEN-1:0] expected_lo;
      logic [XLEN-1:0] compare_hi;
   } rvamo_req_type;

   typedef struct packed {
      logic [2:0]      status;
      logic            mem_write;
      logic [4:0]      access_bytes;
      logic [XLEN-1:0] store_lo;
      logic [XLEN-1:0] store_hi;
      logic            dest_write;
      logic            dest_pair;
      logic [XLEN-1:0] dest_lo;
      logic [XLEN-1:0] dest_hi;
   } rvamo_rsp_type;

   typedef struct packed {
      logic [3:0] granule_bits;
      logic       enable_byte_half;
      logic       enable_cas;
   } rvamo_cfg_type;

   typedef struct packed {
      logic            valid;
      logic [XLEN-1:0] addr;
   } rvamo_resv_type;

   typedef struct packed {
      logic set;
      logic clear;
   } rvamo_resv_upd_type;

   // Sign-extends the low bytes of a value to 64 bits by size code.
   function automatic logic [XLEN-1:0] sext_by_size(input logic [XLEN-1:0] v,
                                                    input logic [2:0] size_code);
      logic [XLEN-1:0] r;
      r = v;
      case (size_code)
         SIZE_BYTE: r = {{(XLEN-8){v[7]}}, v[7:0]};
         SIZE_HALF: r = {{(XLEN-16){v[15]}}, v[15:0]};
         SIZE_WORD: r = {{(XLEN-32){v[31]}}, v[31:0]};
         default:   r = v;
      endcase
      return r;
   endfunction

endpackage

FILE: design/rvamo_exec.sv
module rvamo_exec
   import rvamo_pkg::*;
(
   input  rvamo_req_type      item,
   input  rvamo_cfg_type      cfg,
   input  rvamo_resv_type     resv,
   output rvamo_rsp_type      result,
   output rvamo_resv_upd_type resv_upd
);

   logic [4:0]      width_bytes;
   logic [XLEN-1:0] size_mask;
   logic            illegal;
   logic            is_quad;
   logic            is_lr;
   logic [3:0]      align_mask;
   logic [XLEN-1:0] old_sext;
   logic [XLEN-1:0] mem_val;
   logic [XLEN-1:0] src_val;
   logic [XLEN-1:0] cmp_lo;
   logic [XLEN-1:0] cmp_hi;
   logic [XLEN-1:0] new_val;
   logic [XLEN-1:0] granule_mask;
   logic            sc_ok;

   assign is_quad      = (item.size_code == SIZE_QUAD);
   assign is_lr        = (item.kind == KIND_LR);
   assign align_mask   = 4'(width_bytes - 5'd1);
   assign old_sext     = sext_by_size(item.mem_lo, item.size_code);
   assign mem_val      = item.mem_lo;
   assign src_val      = item.src2_lo;
   assign cmp_lo       = (item.dest_reg == '0) ? '0 : item.expected_lo;
   assign cmp_hi       = (item.dest_reg == '0) ? '0 : item.compare_hi;
   assign granule_mask = {XLEN{1'b1}} << cfg.granule_bits;
   assign sc_ok        = resv.valid && (((resv.addr ^ item.phys_addr) & granule_mask) == '0);

   // Size decode and legality.
   always_comb begin
      width_bytes = 5'd0;
      size_mask   = '1;
      illegal     = 1'b0;
      case (item.size_code)
         SIZE_BYTE: begin
            width_bytes = 5'd1;
            size_mask   = 64'h0000_0000_0000_00FF;
            if (!cfg.enable_byte_half) illegal = 1'b1;
         end
         SIZE_HALF: begin
            width_bytes = 5'd2;
            size_mask   = 64'h0000_0000_0000_FFFF;
            if (!cfg.enable_byte_half) illegal = 1'b1;
         end
         SIZE_WORD: begin
            width_bytes = 5'd4;
            size_mask   = 64'h0000_0000_FFFF_FFFF;
         end
         SIZE_DOUBLE: begin
            width_bytes = 5'd8;
         end
         SIZE_QUAD: begin
            width_bytes = 5'd16;
            if (!cfg.enable_cas) illegal = 1'b1;
         end
         default: illegal = 1'b1;
      endcase
      case (item.kind)
         KIND_ADD, KIND_SWAP, KIND_XOR, KIND_OR, KIND_AND,
         KIND_MIN, KIND_MAX, KIND_MINU, KIND_MAXU: begin
            if (is_quad) illegal = 1'b1;
         end
         KIND_LR, KIND_SC: begin
            if (width_bytes < 5'd4 || is_quad) illegal = 1'b1;
         end
         KIND_CAS: begin
            if (!cfg.enable_cas) illegal = 1'b1;
            if (is_quad && (item.dest_reg[0] || item.src2_reg[0])) illegal = 1'b1;
         end
         default: illegal = 1'b1;
      endcase
   end

   // Value for the read-modify-write operations.
   always_comb begin
      case (item.kind)
         KIND_SWAP: new_val = src_val;
         KIND_ADD:  new_val = mem_val + src_val;
         KIND_OR:   new_val = mem_val | src_val;
         KIND_AND:  new_val = mem_val & src_val;
         KIND_XOR:  new_val = mem_val ^ src_val;
         KIND_MIN:  new_val = ($signed(old_sext) <
                               $signed(sext_by_size(src_val, item.size_code))) ?
                              mem_val : src_val;
         KIND_MAX:  new_val = ($signed(old_sext) >
                               $signed(sext_by_size(src_val, item.size_code))) ?
                              mem_val : src_val;
         KIND_MINU: new_val = ((mem_val & size_mask) < (src_val & size_mask)) ?
                              mem_val : src_val;
         default:   new_val = ((mem_val & size_mask) > (src_val & size_mask)) ?
                              mem_val : src_val;
      endcase
   end

   always_comb begin
      result              = '0;
      result.status       = STATUS_OK;
      result.access_bytes = width_bytes;
      resv_upd            = '0;
      priority if (illegal) begin
         result.status       = STATUS_ILLEGAL;
         result.access_bytes = 5'd1;
      end else if ((item.phys_addr[3:0] & align_mask) != 4'd0) begin
         result.status = is_lr ? STATUS_LOAD_MISALIGN : STATUS_STORE_MISALIGN;
      end else if (item.access_fault) begin
         result.status = is_lr ? STATUS_LOAD_FAULT : STATUS_STORE_FAULT;
         if (item.kind == KIND_SC) resv_upd.clear = 1'b1;
      end else if (is_lr) begin
         result.dest_write = 1'b1;
         result.dest_lo    = old_sext;
         resv_upd.set      = 1'b1;
      end else if (item.kind == KIND_SC) begin
         resv_upd.clear    = 1'b1;
         result.dest_write = 1'b1;
         result.dest_lo    = sc_ok ? '0 : 64'd1;
         if (sc_ok) begin
            result.mem_write = 1'b1;
            result.store_lo  = src_val & size_mask;
         end
      end else if (item.kind == KIND_CAS && is_quad) begin
         if (cmp_lo == item.mem_lo && cmp_hi == item.mem_hi) begin
            result.mem_write = 1'b1;
            result.store_lo  = src_val;
            result.store_hi  = (item.src2_reg == '0) ? '0 : item.src2_hi;
         end
         if (item.dest_reg != '0) begin
            result.dest_write = 1'b1;
            result.dest_pair  = 1'b1;
            result.dest_lo    = item.mem_lo;
            result.dest_hi    = item.mem_hi;
         end
      end else if (item.kind == KIND_CAS) begin
         if ((cmp_lo & size_mask) == (mem_val & size_mask)) begin
            result.mem_write = 1'b1;
            result.store_lo  = src_val & size_mask;
         end
         result.dest_write = 1'b1;
         result.dest_lo    = old_sext;
      end else begin
         result.mem_write  = 1'b1;
         result.store_lo   = new_val & size_mask;
         result.dest_write = 1'b1;
         result.dest_lo    = old_sext;
      end
   end

endmodule

FILE: design/riscv_atomic_memory_op_unit.sv
// Each accepted request item passes through the input register, then the result
// register, before it leaves as a response item.
// Throughput: one item per cycle while rsp_stall is low; the LR/SC reservation is
// updated as an item leaves the input register, so the next item sees it at once.
// Reset (synchronous, active high) empties both stages, drops the reservation
// and loads granule 6 with byte/half and CAS enabled.
module riscv_atomic_memory_op_unit
   import rvamo_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  rvamo_req_type req_payload,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rvamo_rsp_type rsp_payload,
   input  logic          csr_write_enable,
   input  logic [1:0]    csr_index,
   input  logic [3:0]    csr_write_data
);

   rvamo_req_type      req_ff;
   logic               req_valid_ff;
   logic               req_valid_in;
   rvamo_rsp_type      rsp_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rvamo_cfg_type      cfg_ff;
   rvamo_resv_type     resv_ff;
   rvamo_resv_type     resv_in;
   rvamo_rsp_type      exec_result;
   rvamo_resv_upd_type exec_resv_upd;
   logic               advance;
   logic               req_take;

   // The result register may load whenever it is empty or being drained.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;

   rvamo_exec u_exec (
      .item     (req_ff),
      .cfg      (cfg_ff),
      .resv     (resv_ff),
      .result   (exec_result),
      .resv_upd (exec_resv_upd)
   );

   always_comb begin
      resv_in = resv_ff;
      if (req_valid_ff && advance) begin
         if (exec_resv_upd.set) begin
            resv_in.valid = 1'b1;
            resv_in.addr  = req_ff.phys_addr;
         end else if (exec_resv_upd.clear) begin
            resv_in.valid = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         resv_ff      <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         resv_ff      <= resv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.granule_bits     <= GRANULE_BITS_RESET;
         cfg_ff.enable_byte_half <= 1'b1;
         cfg_ff.enable_cas       <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GRANULE_BITS: cfg_ff.granule_bits     <= csr_write_data;
            CSR_BYTE_HALF:    cfg_ff.enable_byte_half <= csr_write_data[0];
            CSR_CAS:          cfg_ff.enable_cas       <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) req_ff <= req_payload;
      if (req_valid_ff && advance) rsp_ff <= exec_result;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: design/rvamo_checker.sv
module rvamo_checker
   import rvamo_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input rvamo_req_type req_payload,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input rvamo_rsp_type rsp_payload
);

   // Nothing is presented in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response item holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response item changed");

   // Only a successful item may write memory or rd.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK |->
         !rsp_payload.mem_write && !rsp_payload.dest_write && !rsp_payload.dest_pair)
      else $error("write side effect on a failed item");

   // A pair write always includes rd itself and only comes with a 16-byte access.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.dest_pair |->
         rsp_payload.dest_write && rsp_payload.access_bytes == 5'd16)
      else $error("pair write without rd write or quad size");

   // The access size is always a single power of two.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_payload.access_bytes))
      else $error("access size is not a power of two");

endmodule

bind riscv_atomic_memory_op_unit rvamo_checker u_rvamo_checker (.*);
